@@ sv/far_pkg.sv @@
`timescale 1ns / 1ps
package far_pkg;
    localparam int OPW = 16;
    localparam int PW = 2 * OPW;
    localparam int MW = PW + 1;
    localparam int NUMW = 33;
    localparam int DENW = 32;
    localparam int CW = $clog2(MW + 1);

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    typedef struct packed {
        logic        start;
        logic [MW-1:0] dividend;
        logic [MW-1:0] divisor;
    } t_div_req;
endpackage

@@ sv/far_if.sv @@
`timescale 1ns / 1ps
interface far_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic signed [15:0] num_a;
    logic signed [15:0] den_a;
    logic signed [15:0] num_b;
    logic signed [15:0] den_b;
    modport source (output valid, action, num_a, den_a, num_b, den_b, input ready);
    modport sink (input valid, action, num_a, den_a, num_b, den_b, output ready);
endinterface

interface far_out_if;
    logic        valid;
    logic        ready;
    logic signed [32:0] res_num;
    logic signed [31:0] res_den;
    logic        status;
    modport source (output valid, res_num, res_den, status, input ready);
    modport sink (input valid, res_num, res_den, status, output ready);
endinterface

@@ sv/far_div.sv @@
`timescale 1ns / 1ps
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
module far_div import far_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_req      i_req,
    output logic          o_done,
    output logic [MW-1:0] o_quot,
    output logic [MW-1:0] o_rem
);
    logic [MW-1:0] r_q, r_r, r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [MW:0]   w_sh;
    logic [MW:0]   w_sub;

    assign w_sh  = {r_r, r_q[MW-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    // Shift in one dividend bit and try subtraction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_q    <= i_req.dividend;
                r_d    <= i_req.divisor;
                r_r    <= '0;
                r_cnt  <= CW'(MW);
            end else if (r_busy) begin
                if (w_sub[MW]) begin
                    r_r <= w_sh[MW-1:0];
                    r_q <= {r_q[MW-2:0], 1'b0};
                end else begin
                    r_r <= w_sub[MW-1:0];
                    r_q <= {r_q[MW-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

@@ sv/fraction_arith_reduce_core.sv @@
`timescale 1ns / 1ps
// Rational arithmetic with Euclid reduction.
// Input channel i_in carries an operation (add, subtract, multiply, divide)
// and two signed 16-bit fractions. Output channel o_out carries the reduced
// numerator (33 bits), denominator (32 bits) and a status bit that is set
// when both raw values are zero and no reduction was possible.
// One transaction is worked at a time; i_in.ready is high only when idle.
// After acceptance the products are formed on the single multiplier, with
// an extra step for add and subtract, then the Euclid remainder steps run and
// numerator and denominator are divided by the gcd. Each division starts the
// divider, takes 33 quotient bits and collects the result. When both raw
// values are zero the two final divisions are skipped. All divisions run
// through one shared restoring divider producing one bit per cycle, which
// sets the rate. The next transaction is taken only after the sequencer has
// returned to idle from the accepted result. The result is held in an
// output register until taken; a stalled receiver holds the block in done state.
// Reset is synchronous and active low and returns the sequencer to idle.
module fraction_arith_reduce_core import far_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    far_in_if.sink    i_in,
    far_out_if.source o_out
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MUL1 = 8'b00000010,
        S_MUL2 = 8'b00000100,
        S_SUM  = 8'b00001000,
        S_EUC  = 8'b00010000,
        S_DIVN = 8'b00100000,
        S_DIVD = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    t_state r_state;
    logic [1:0] r_act;
    logic r_nan, r_dan, r_nbn, r_dbn;
    logic [OPW-1:0] r_nam, r_dam, r_nbm, r_dbm;
    logic [MW-1:0] r_p1, r_nm, r_dm, r_a, r_b, r_gm;
    logic r_p1n, r_nn, r_dn, r_gn, r_odd, r_wait;
    logic [MW-1:0] r_qn;
    logic signed [32:0] r_rn;
    logic signed [31:0] r_rd;
    logic r_st;

    t_div_req w_req;
    logic w_done;
    logic [MW-1:0] w_q, w_r;
    logic [OPW-1:0] w_m1, w_m2;
    logic [PW-1:0] w_prod;

    function automatic logic [OPW-1:0] f_mag(input logic [OPW-1:0] v);
        f_mag = v[OPW-1] ? (~v + 1'b1) : v;
    endfunction

    // Operand selection for the single multiplier.
    always_comb begin
        w_m1 = r_nam;
        w_m2 = r_dbm;
        if (r_state == S_MUL1) begin
            if (r_act == ACT_MUL) w_m2 = r_nbm;
        end else if (r_state == S_MUL2 && (r_act == ACT_ADD || r_act == ACT_SUB)) begin
            w_m1 = r_nbm;
            w_m2 = r_dam;
        end else begin
            w_m1 = r_dam;
            w_m2 = (r_act == ACT_DIV) ? r_nbm : r_dbm;
        end
    end
    assign w_prod = w_m1 * w_m2;

    far_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .o_done(w_done), .o_quot(w_q), .o_rem(w_r)
    );

    always_comb begin
        w_req.start = 1'b0;
        w_req.dividend = r_a;
        w_req.divisor = r_b;
        if (r_state == S_EUC && !r_wait && r_b != '0) w_req.start = 1'b1;
        if (r_state == S_DIVN && !r_wait) begin
            w_req.start = 1'b1;
            w_req.dividend = r_nm;
            w_req.divisor = r_gm;
        end
        if (r_state == S_DIVD && !r_wait) begin
            w_req.start = 1'b1;
            w_req.dividend = r_dm;
            w_req.divisor = r_gm;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.res_num = r_rn;
    assign o_out.res_den = r_rd;
    assign o_out.status = r_st;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_act <= i_in.action;
                        r_nan <= i_in.num_a[OPW-1]; r_nam <= f_mag(i_in.num_a);
                        r_dan <= i_in.den_a[OPW-1]; r_dam <= f_mag(i_in.den_a);
                        r_nbn <= i_in.num_b[OPW-1]; r_nbm <= f_mag(i_in.num_b);
                        r_dbn <= i_in.den_b[OPW-1]; r_dbm <= f_mag(i_in.den_b);
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p1 <= MW'(w_prod);
                    r_p1n <= (w_prod != '0) && (r_nan != ((r_act == ACT_MUL) ? r_nbn : r_dbn));
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    if (r_act == ACT_MUL || r_act == ACT_DIV) begin
                        r_nm <= r_p1; r_nn <= r_p1n;
                        r_dm <= MW'(w_prod);
                        r_dn <= (w_prod != '0) &&
                                (r_dan != ((r_act == ACT_DIV) ? r_nbn : r_dbn));
                        r_state <= S_SUM;
                    end else begin
                        r_a <= MW'(w_prod);
                        r_gn <= (w_prod != '0) && ((r_nbn != r_dan) != (r_act == ACT_SUB));
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_act == ACT_ADD || r_act == ACT_SUB) begin
                        // Combine the two cross products in sign-magnitude.
                        if (r_p1n == r_gn) begin
                            r_nm <= r_p1 + r_a; r_nn <= r_p1n && (r_p1 + r_a != '0);
                        end else if (r_p1 >= r_a) begin
                            r_nm <= r_p1 - r_a; r_nn <= r_p1n && (r_p1 != r_a);
                        end else begin
                            r_nm <= r_a - r_p1; r_nn <= r_gn;
                        end
                        r_dm <= MW'(w_prod);
                        r_dn <= (w_prod != '0) && (r_dan != r_dbn);
                        // The raw pair is ready next cycle; start Euclid then.
                        r_act <= ACT_MUL;
                    end else begin
                        r_a <= r_nm; r_b <= r_dm; r_odd <= 1'b0;
                        r_state <= S_EUC;
                    end
                end
                S_EUC: begin
                    if (!r_wait) begin
                        if (r_b == '0) begin
                            r_gm <= r_a;
                            r_gn <= (r_a != '0) && (r_odd ? r_dn : r_nn);
                            if (r_a == '0) begin
                                r_rn <= '0; r_rd <= '0; r_st <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_DIVN;
                            end
                        end else begin
                            r_wait <= 1'b1;
                        end
                    end else if (w_done) begin
                        r_a <= r_b; r_b <= w_r; r_odd <= ~r_odd;
                        r_wait <= 1'b0;
                    end
                end
                S_DIVN: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (w_done) begin
                        r_qn <= w_q; r_wait <= 1'b0; r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (w_done) begin
                        r_rn <= (r_nn != r_gn) ? NUMW'(-r_qn) : NUMW'(r_qn);
                        r_rd <= (r_dn != r_gn) ? DENW'(-w_q) : DENW'(w_q);
                        r_st <= 1'b0; r_wait <= 1'b0; r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ tb/sv/tb_fraction_arith_reduce_core.sv @@
`timescale 1ns / 1ps
// Signed magnitude value used by the fraction predictor.
typedef struct {
    bit              neg;
    longint unsigned mag;
} t_smag;

// Expected reduced fraction for one input transaction.
typedef struct {
    logic signed [32:0] res_num;
    logic signed [31:0] res_den;
    logic               status;
} t_frac_res;

class fraction_scoreboard;
    t_frac_res pending_q[$];
    int        n_errors;

    function t_smag to_smag(logic signed [15:0] v);
        t_smag r;
        longint sv;
        sv = v;
        r.neg = sv < 0;
        r.mag = r.neg ? -sv : sv;
        return r;
    endfunction

    function t_smag smul(t_smag a, t_smag b);
        t_smag r;
        r.mag = a.mag * b.mag;
        r.neg = (r.mag != 0) && (a.neg != b.neg);
        return r;
    endfunction

    function t_smag sadd(t_smag a, t_smag b);
        t_smag r;
        if (a.neg == b.neg) begin
            r.mag = a.mag + b.mag;
            r.neg = a.neg;
        end else if (a.mag >= b.mag) begin
            r.mag = a.mag - b.mag;
            r.neg = a.neg;
        end else begin
            r.mag = b.mag - a.mag;
            r.neg = b.neg;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function logic signed [63:0] to_signed(t_smag a);
        longint v;
        v = a.mag;
        return a.neg ? -v : v;
    endfunction

    // Work out the reduced fraction for an accepted input transaction.
    function void note_input(logic [1:0] act, logic signed [15:0] na_i,
                             logic signed [15:0] da_i, logic signed [15:0] nb_i,
                             logic signed [15:0] db_i);
        t_smag na, da, nb, db, n, d, g, q;
        longint unsigned x, y, t;
        int steps;
        logic signed [63:0] w;
        t_frac_res e;
        na = to_smag(na_i); da = to_smag(da_i);
        nb = to_smag(nb_i); db = to_smag(db_i);
        case (act)
            far_pkg::ACT_ADD: begin
                n = sadd(smul(na, db), smul(nb, da));
                d = smul(da, db);
            end
            far_pkg::ACT_SUB: begin
                q = smul(nb, da);
                if (q.mag != 0) q.neg = !q.neg;
                n = sadd(smul(na, db), q);
                d = smul(da, db);
            end
            far_pkg::ACT_MUL: begin
                n = smul(na, nb);
                d = smul(da, db);
            end
            default: begin
                n = smul(na, db);
                d = smul(da, nb);
            end
        endcase
        // Truncated Euclid: sign of the gcd alternates with the step count.
        x = n.mag; y = d.mag; steps = 0;
        while (y != 0) begin
            t = x % y; x = y; y = t; steps++;
        end
        g.mag = x;
        g.neg = (x != 0) && (steps[0] ? d.neg : n.neg);
        if (g.mag == 0) begin
            w = to_signed(n); e.res_num = w[32:0];
            w = to_signed(d); e.res_den = w[31:0];
            e.status = 1'b1;
        end else begin
            q.mag = n.mag / g.mag; q.neg = (q.mag != 0) && (n.neg != g.neg);
            w = to_signed(q); e.res_num = w[32:0];
            q.mag = d.mag / g.mag; q.neg = (q.mag != 0) && (d.neg != g.neg);
            w = to_signed(q); e.res_den = w[31:0];
            e.status = 1'b0;
        end
        pending_q.push_back(e);
    endfunction

    function void report(string msg);
        $display("MISMATCH: %s", msg);
        n_errors++;
    endfunction

    // Compare one result transaction with the oldest expectation.
    function void check_result(logic signed [32:0] rn, logic signed [31:0] rd,
                               logic st);
        t_frac_res e;
        if (pending_q.size() == 0) begin
            report($sformatf("unexpected result %0d/%0d st=%0b", rn, rd, st));
            return;
        end
        e = pending_q.pop_front();
        if (rn !== e.res_num)
            report($sformatf("res_num got %0d exp %0d", rn, e.res_num));
        if (rd !== e.res_den)
            report($sformatf("res_den got %0d exp %0d", rd, e.res_den));
        if (st !== e.status)
            report($sformatf("status got %0b exp %0b", st, e.status));
    endfunction
endclass

module tb_fraction_arith_reduce_core;
    import far_pkg::*;

    localparam int N_RANDOM = 350;
    localparam longint CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    far_in_if  in_ch();
    far_out_if out_ch();

    fraction_scoreboard frac_sb = new();
    int  send_idle_pct = 17;
    int  recv_idle_pct = 86;
    bit  recv_hold = 1'b0;
    longint n_cycles = 0;

    fraction_arith_reduce_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = ACT_ADD;
        in_ch.num_a = '0; in_ch.den_a = '0; in_ch.num_b = '0; in_ch.den_b = '0;
        out_ch.ready = 1'b0;
    end

    // Receiver readiness, decided each cycle; a hold forces a long stall.
    always @(posedge i_clk) begin
        if (!i_rst_n || recv_hold) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every accepted result transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            frac_sb.check_result(out_ch.res_num, out_ch.res_den, out_ch.status);
    end

    // Run limit.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one transaction and wait until it is accepted. Valid stays high
    // after acceptance so that back-to-back transactions need no gap; idle
    // cycles and the drain wait take it low.
    task automatic send_fraction(logic [1:0] act, logic signed [15:0] na,
                                 logic signed [15:0] da, logic signed [15:0] nb,
                                 logic signed [15:0] db);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.num_a <= na; in_ch.den_a <= da; in_ch.num_b <= nb; in_ch.den_b <= db;
        do @(posedge i_clk); while (!in_ch.ready);
        frac_sb.note_input(act, na, da, nb, db);
    endtask

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(6)) - 3);
            3: return 16'(int'($urandom_range(400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(int count);
        logic [15:0] v [4];
        repeat (count) begin
            foreach (v[k]) v[k] = pick_operand();
            send_fraction(2'($urandom_range(3)), v[0], v[1], v[2], v[3]);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (frac_sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases: extremes, each operation, zero gcd, zero denominator.
        send_fraction(ACT_ADD, 16'sd0, 16'sd5, 16'sd0, 16'sd7);
        send_fraction(ACT_MUL, 16'sd0, 16'sd0, 16'sd3, 16'sd4);
        send_fraction(ACT_SUB, 16'sd3, 16'sd4, 16'sd3, 16'sd4);
        send_fraction(ACT_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd5);
        send_fraction(ACT_DIV, -16'sd1, 16'sd2, 16'sd0, 16'sd5);
        send_fraction(ACT_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd0);
        send_fraction(ACT_MUL, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_fraction(ACT_ADD, -16'sd32768, 16'sd1, -16'sd32768, 16'sd1);
        send_fraction(ACT_SUB, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
        send_fraction(ACT_DIV, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd1);
        send_fraction(ACT_MUL, 16'sd6, -16'sd4, -16'sd10, 16'sd9);
        send_fraction(ACT_ADD, 16'sd1, 16'sd3, 16'sd1, 16'sd6);
        send_fraction(ACT_SUB, -16'sd5, 16'sd8, 16'sd7, -16'sd12);
        send_fraction(ACT_DIV, 16'sd21, 16'sd13, 16'sd34, 16'sd55);
        send_fraction(ACT_MUL, 16'sd28657, 16'sd17711, 16'sd17711, 16'sd10946);
        send_fraction(ACT_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0);

        // Long receiver stall while the sender keeps offering.
        recv_hold = 1'b1;
        fork
            begin
                repeat (4000) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            send_random(4);
        join
        // Sender pauses until every result has come.
        wait_drained();

        send_random(N_RANDOM / 3);
        send_idle_pct = 86; recv_idle_pct = 17;
        send_random(N_RANDOM / 3);
        send_idle_pct = 0; recv_idle_pct = 0;
        send_random(N_RANDOM - 2 * (N_RANDOM / 3));

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (frac_sb.n_errors == 0 && frac_sb.pending_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

@@ fraction_arith_reduce_core.f @@
sv/far_pkg.sv
sv/far_if.sv
sv/far_div.sv
sv/fraction_arith_reduce_core.sv
tb/sv/tb_fraction_arith_reduce_core.sv
